### hdl/assert_macros.svh
// Assertion macros shared by the bit packer RTL.
// Depends on nothing; included by the files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is asserted.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, switched off while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is also checked across reset.
`define ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/mbp_pkg.sv
// Shared types and constants of the MSB-first bit packer.
// Depends on nothing; imported by every module of the block.
package mbp_pkg;

    // Widest code the block may be configured for, and the effective limit.
    localparam int CODE_WIDTH_MAX = 32;
    localparam int CODE_LIMIT     = (CODE_WIDTH_MAX > 32) ? 32 : CODE_WIDTH_MAX;

    // Field widths.
    localparam int CODE_BITS  = 32;
    localparam int WIDTH_BITS = 6;
    localparam int BYTE_BITS  = 8;
    localparam int HELD_BITS  = 3;
    localparam int ACC_BITS   = CODE_BITS + BYTE_BITS;

    // Queue between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Item operations.
    typedef enum logic [0:0] {
        OP_WRITE = 1'b0,
        OP_FLUSH = 1'b1
    } mbp_op_t;

    // One queued run of bytes: up to four bytes, first in bits 31:24.
    typedef struct packed {
        logic [CODE_BITS-1:0] bytes;
        logic [1:0]           last_idx;
    } mbp_entry_t;

    // Queue status seen by the top level and the back.
    typedef struct packed {
        logic full;
        logic empty;
    } mbp_qstat_t;

    // Front status, exposed for checking.
    typedef struct packed {
        logic [HELD_BITS-1:0] held;
    } mbp_fstat_t;

endpackage

### hdl/mbp_front.sv
// Front part of the bit packer: accepts items, merges codes into the pending byte.
// Depends on mbp_pkg; pushes runs of completed bytes into mbp_queue.
module mbp_front (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               accept,
    input  mbp_pkg::mbp_op_t                   opcode,
    input  logic [mbp_pkg::CODE_BITS-1:0]      code_value,
    input  logic [mbp_pkg::WIDTH_BITS-1:0]     code_width,
    output logic                               push,
    output mbp_pkg::mbp_entry_t                entry,
    output mbp_pkg::mbp_fstat_t                fstat
);
    import mbp_pkg::*;

    localparam logic [WIDTH_BITS-1:0] LIMIT_W = WIDTH_BITS'(CODE_LIMIT);
    localparam logic [WIDTH_BITS-1:0] FULL_W  = WIDTH_BITS'(CODE_BITS);

    logic [BYTE_BITS-1:0]  pending_reg, pending_next;
    logic [HELD_BITS-1:0]  held_reg, held_next;

    logic [WIDTH_BITS-1:0] width_eff;
    logic [CODE_BITS-1:0]  code_left;
    logic [ACC_BITS-1:0]   acc;
    logic [ACC_BITS-1:0]   acc_rest;
    logic [WIDTH_BITS-1:0] total;
    logic [2:0]            nbytes;

    // Saturate the width, then left-align the code; bits above the width shift out.
    always_comb begin
        width_eff = (code_width > LIMIT_W) ? LIMIT_W : code_width;
        code_left = code_value << (FULL_W - width_eff);
        acc       = {pending_reg, {CODE_BITS{1'b0}}}
                  | ({code_left, {BYTE_BITS{1'b0}}} >> held_reg);
        total     = WIDTH_BITS'(held_reg) + width_eff;
        nbytes    = total[WIDTH_BITS-1:3];
        acc_rest  = acc << {nbytes, 3'b000};
    end

    // Decide what a beat does to the pending byte and to the queue.
    always_comb begin
        pending_next = pending_reg;
        held_next    = held_reg;
        push         = 1'b0;
        entry.bytes  = acc[ACC_BITS-1 -: CODE_BITS];
        entry.last_idx = 2'(nbytes - 3'd1);
        if (accept) begin
            if (opcode == OP_FLUSH) begin
                push           = (held_reg != '0);
                entry.bytes    = {pending_reg, {(CODE_BITS-BYTE_BITS){1'b0}}};
                entry.last_idx = 2'd0;
                pending_next   = '0;
                held_next      = '0;
            end else if (width_eff != '0) begin
                push         = (nbytes != 3'd0);
                pending_next = acc_rest[ACC_BITS-1 -: BYTE_BITS];
                held_next    = total[HELD_BITS-1:0];
            end
        end
    end

    // Pending state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
            held_reg    <= '0;
        end else begin
            pending_reg <= pending_next;
            held_reg    <= held_next;
        end
    end

    assign fstat.held = held_reg;

endmodule

### hdl/mbp_queue.sv
// Short queue of byte runs between the front and the back of the bit packer.
// Depends on mbp_pkg for the entry type and the depth.
module mbp_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  mbp_pkg::mbp_entry_t   wr_entry,
    input  logic                  pop,
    output mbp_pkg::mbp_entry_t   rd_entry,
    output mbp_pkg::mbp_qstat_t   qstat
);
    import mbp_pkg::*;

    localparam logic [QPTR_W-1:0] PTR_LAST = QPTR_W'(QUEUE_DEPTH - 1);
    localparam logic [QCNT_W-1:0] CNT_FULL = QCNT_W'(QUEUE_DEPTH);

    mbp_entry_t          slots_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                do_push, do_pop;

    // Pointer and fill count updates; a pop of an empty queue is ignored.
    always_comb begin
        do_push     = push && (count_reg != CNT_FULL);
        do_pop      = pop && (count_reg != '0);
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots_reg[wr_ptr_reg] <= wr_entry;
        end
    end

    assign rd_entry    = slots_reg[rd_ptr_reg];
    assign qstat.full  = (count_reg == CNT_FULL);
    assign qstat.empty = (count_reg == '0);

endmodule

### hdl/mbp_back.sv
// Back of the packer: unrolls queued runs into one byte per cycle unless stalled.
// Depends on mbp_pkg; pops entries from mbp_queue and drives the result channel.
module mbp_back (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  mbp_pkg::mbp_entry_t               head,
    input  mbp_pkg::mbp_qstat_t               qstat,
    output logic                              pop,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [mbp_pkg::BYTE_BITS-1:0]     m_out_byte,
    output logic                              m_last_of_run
);
    import mbp_pkg::*;

    mbp_entry_t            cur_reg;
    logic                  cur_valid_reg, cur_valid_next;
    logic [1:0]            idx_reg, idx_next;
    logic                  m_valid_reg, m_valid_next;
    logic [BYTE_BITS-1:0]  byte_reg;
    logic                  last_reg;

    logic                  out_load, emit, cur_last;
    logic [BYTE_BITS-1:0]  byte_sel;

    // Pick the byte at the current index, first byte in the top bits.
    always_comb begin
        case (idx_reg)
            2'd0:    byte_sel = cur_reg.bytes[31:24];
            2'd1:    byte_sel = cur_reg.bytes[23:16];
            2'd2:    byte_sel = cur_reg.bytes[15:8];
            default: byte_sel = cur_reg.bytes[7:0];
        endcase
    end

    // Emit when the output register is free, fetch the next run as this one ends.
    always_comb begin
        out_load       = !m_valid_reg || m_ready;
        cur_last       = (idx_reg == cur_reg.last_idx);
        emit           = cur_valid_reg && out_load;
        pop            = !qstat.empty && (!cur_valid_reg || (emit && cur_last));
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        if (pop) begin
            cur_valid_next = 1'b1;
            idx_next       = '0;
        end else if (emit) begin
            cur_valid_next = !cur_last;
            idx_next       = idx_reg + 1'b1;
        end
        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (pop) begin
            cur_reg <= head;
        end
        if (emit) begin
            byte_reg <= byte_sel;
            last_reg <= cur_last;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_out_byte    = byte_reg;
    assign m_last_of_run = last_reg;

endmodule

### hdl/msb_first_bit_packer.sv
// MSB-first bit packer. A write beat appends the low code_width bits (0 to 32) of
// code_value, first bit first, after the pending partial byte; every completed byte
// leaves on the result channel with last_of_run set on the final byte of that beat.
// A flush beat sends the partial byte, zero padded in its low bits, if one is pending.
// The front merges one input beat per cycle while the two-entry run queue has room;
// the back sends one byte per cycle while m_ready allows, so an item that completes
// n bytes (one to four) holds the output for those bytes; the queue lets the front
// take new beats meanwhile. Bytes pass the queue, run and output registers in order.
// Depends on mbp_pkg, mbp_front, mbp_queue, mbp_back and assert_macros.svh.
`include "assert_macros.svh"

module msb_first_bit_packer (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_opcode,
    input  logic [mbp_pkg::CODE_BITS-1:0]      s_code_value,
    input  logic [mbp_pkg::WIDTH_BITS-1:0]     s_code_width,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [mbp_pkg::BYTE_BITS-1:0]      m_out_byte,
    output logic                               m_last_of_run
);
    import mbp_pkg::*;

    logic        accept;
    logic        flush_beat;
    logic        push, pop;
    mbp_entry_t  push_entry, head_entry;
    mbp_qstat_t  qstat;
    mbp_fstat_t  fstat;

    // The front takes a beat whenever the queue can hold what it may produce.
    assign s_ready    = !qstat.full;
    assign accept     = s_valid && s_ready;
    assign flush_beat = accept && (s_opcode == OP_FLUSH);

    mbp_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .opcode     (mbp_op_t'(s_opcode)),
        .code_value (s_code_value),
        .code_width (s_code_width),
        .push       (push),
        .entry      (push_entry),
        .fstat      (fstat)
    );

    mbp_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .wr_entry (push_entry),
        .pop      (pop),
        .rd_entry (head_entry),
        .qstat    (qstat)
    );

    mbp_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head          (head_entry),
        .qstat         (qstat),
        .pop           (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_last_of_run (m_last_of_run)
    );

    // The front never pushes a run into a full queue.
    `ASSERT_IMPL(a_no_push_when_full, aclk, aresetn, push, !qstat.full, "push into full queue")

    // A flush leaves nothing pending.
    `ASSERT_NEXT(a_flush_clears, aclk, aresetn, flush_beat, fstat.held == '0, "flush kept bits")

    // No byte is offered in the cycle after reset.
    `ASSERT_NEXT_ALWAYS(a_reset_quiet, aclk, !aresetn, !m_valid, "output valid after reset")

endmodule

### tb/tb_top.sv
// Self-checking testbench for the MSB-first bit packer (msb_first_bit_packer).
// Depends on mbp_pkg and the packer RTL; predicts every output byte and checks it in order.
module tb_top;
    import mbp_pkg::*;

    localparam int CLK_HALF    = 5;
    localparam int RESET_CYC   = 9;
    localparam int RANDOM_GOAL = 100;
    localparam int STALL_LIMIT = 1000;
    localparam int DRAIN_CYC   = 20;

    // Receiver behavior modes.
    typedef enum int {
        RX_OPEN,
        RX_RANDOM,
        RX_SPARSE
    } rx_mode_t;

    // Tracks the packer state and holds the bytes that are still due.
    class byte_stream_board;
        logic [7:0] part_byte;
        int         free_cnt;
        logic [7:0] due_byte[$];
        logic       due_last[$];
        int         mismatches;
        int         bytes_checked;

        function new();
            part_byte     = 8'h00;
            free_cnt      = 8;
            mismatches    = 0;
            bytes_checked = 0;
        endfunction

        function int outstanding();
            return due_byte.size();
        endfunction

        // Note an accepted input beat and queue the bytes it completes.
        function void add_item(mbp_op_t op, logic [31:0] code, logic [5:0] width);
            int          w;
            int          total;
            int          held;
            int          n;
            logic [63:0] acc;
            logic [63:0] mask;
            n = 0;
            if (op == OP_FLUSH) begin
                if (free_cnt < 8) begin
                    due_byte.push_back(part_byte);
                    due_last.push_back(1'b1);
                end
                part_byte = 8'h00;
                free_cnt  = 8;
                return;
            end
            w = (int'(width) > CODE_LIMIT) ? CODE_LIMIT : int'(width);
            if (w == 0) return;
            held  = 8 - free_cnt;
            mask  = (64'd1 << w) - 64'd1;
            acc   = ((64'(part_byte) >> free_cnt) << w) | (64'(code) & mask);
            total = held + w;
            while (total >= 8) begin
                total -= 8;
                due_byte.push_back(8'(acc >> total));
                due_last.push_back(1'b0);
                n++;
            end
            if (n > 0) due_last[due_last.size() - 1] = 1'b1;
            part_byte = 8'((acc & ((64'd1 << total) - 64'd1)) << (8 - total));
            free_cnt  = 8 - total;
        endfunction

        // Compare one output beat with the oldest byte that is due.
        function void check_byte(logic [7:0] got_byte, logic got_last);
            logic [7:0] exp_byte;
            logic       exp_last;
            if (due_byte.size() == 0) begin
                $error("unexpected output beat: out_byte=%02h last_of_run=%0b",
                       got_byte, got_last);
                mismatches++;
                return;
            end
            exp_byte = due_byte.pop_front();
            exp_last = due_last.pop_front();
            bytes_checked++;
            if (got_byte !== exp_byte) begin
                $error("out_byte mismatch: expected %02h, actual %02h", exp_byte, got_byte);
                mismatches++;
            end
            if (got_last !== exp_last) begin
                $error("last_of_run mismatch: expected %0b, actual %0b", exp_last, got_last);
                mismatches++;
            end
        endfunction
    endclass

    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic                  s_valid       = 1'b0;
    logic                  s_ready;
    logic                  s_opcode      = 1'b0;
    logic [CODE_BITS-1:0]  s_code_value  = '0;
    logic [WIDTH_BITS-1:0] s_code_width  = '0;
    logic                  m_valid;
    logic                  m_ready       = 1'b0;
    logic [BYTE_BITS-1:0]  m_out_byte;
    logic                  m_last_of_run;

    byte_stream_board board = new();

    int       beats_sent   = 0;
    int       flush_beats  = 0;
    int       wide_beats   = 0;
    int       idle_cycles  = 0;
    rx_mode_t rx_mode      = RX_OPEN;
    int       rx_timer     = 0;
    int       rx_stall     = 0;

    msb_first_bit_packer dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_opcode      (s_opcode),
        .s_code_value  (s_code_value),
        .s_code_width  (s_code_width),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_last_of_run (m_last_of_run)
    );

    // Free-running clock.
    always #CLK_HALF aclk = ~aclk;

    // Receiver: switches between open, random stalls and one-in-four readiness.
    always @(posedge aclk) begin
        if (rx_timer == 0) begin
            rx_mode  <= rx_mode_t'($urandom_range(0, 2));
            rx_timer <= $urandom_range(30, 120);
        end else begin
            rx_timer <= rx_timer - 1;
        end
        case (rx_mode)
            RX_OPEN: begin
                m_ready <= 1'b1;
            end
            RX_RANDOM: begin
                if (rx_stall > 0) begin
                    rx_stall <= rx_stall - 1;
                    m_ready  <= 1'b0;
                end else if ($urandom_range(0, 2) == 0) begin
                    rx_stall <= $urandom_range(1, 6);
                    m_ready  <= 1'b0;
                end else begin
                    m_ready <= 1'b1;
                end
            end
            default: begin
                m_ready <= (rx_timer % 4 == 0);
            end
        endcase
    end

    // Output monitor.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) board.check_byte(m_out_byte, m_last_of_run);
    end

    // Watchdog on cycles with no beat on either channel.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Watchdog expired after %0d idle cycles.", idle_cycles);
            $display("FAIL");
            $finish;
        end
    end

    // Present one input beat and hold it until it is accepted.
    task automatic send_item(input mbp_op_t op, input logic [31:0] code,
                             input logic [5:0] width);
        s_valid      <= 1'b1;
        s_opcode     <= op;
        s_code_value <= code;
        s_code_width <= width;
        do @(posedge aclk); while (s_ready !== 1'b1);
        board.add_item(op, code, width);
        beats_sent++;
        if (op == OP_FLUSH) flush_beats++;
        else if (int'(width) > CODE_LIMIT) wide_beats++;
    endtask

    // Drop valid for a number of cycles; zero keeps the stream back to back.
    task automatic idle_sender(input int cycles);
        if (cycles > 0) begin
            s_valid <= 1'b0;
            repeat (cycles) @(posedge aclk);
        end
    endtask

    // Pick one random beat, mostly well-formed writes with some flushes and odd widths.
    task automatic send_random(output int counted);
        int          pick;
        logic [31:0] code;
        logic [5:0]  width;
        pick    = $urandom_range(0, 99);
        code    = $urandom;
        counted = 1;
        if ($urandom_range(0, 9) == 0) code = ($urandom_range(0, 1) != 0) ? '1 : '0;
        if (pick < 10) begin
            send_item(OP_FLUSH, code, 6'($urandom_range(0, 63)));
        end else if (pick < 15) begin
            send_item(OP_WRITE, code, 6'd0);
            counted = 0;
        end else if (pick < 22) begin
            send_item(OP_WRITE, code, 6'($urandom_range(33, 63)));
        end else if (pick < 60) begin
            send_item(OP_WRITE, code, 6'($urandom_range(1, 8)));
        end else begin
            send_item(OP_WRITE, code, 6'($urandom_range(1, 32)));
        end
    endtask

    // Main sequence: reset, directed beats, random bursts, drain and verdict.
    initial begin
        int done;
        int burst;
        int counted;
        bit paused;
        done   = 0;
        paused = 1'b0;

        repeat (RESET_CYC) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Flush with nothing pending and a zero-width write must produce nothing.
        send_item(OP_FLUSH, 32'hFFFF_FFFF, 6'd63);
        send_item(OP_WRITE, 32'hFFFF_FFFF, 6'd0);
        // Full-width codes on a byte boundary.
        send_item(OP_WRITE, 32'hFFFF_FFFF, 6'd32);
        send_item(OP_WRITE, 32'h0000_0000, 6'd32);
        // Short codes that fit in the partial byte are merged, not overwritten.
        send_item(OP_WRITE, 32'hFFFF_FFFF, 6'd3);
        send_item(OP_WRITE, 32'h0000_0000, 6'd2);
        send_item(OP_WRITE, 32'hFFFF_FFFF, 6'd2);
        send_item(OP_WRITE, 32'h0000_0001, 6'd1);
        // Partial byte, then flush with padding, then a second flush with nothing left.
        send_item(OP_WRITE, 32'hFFFF_FFF5, 6'd5);
        send_item(OP_FLUSH, 32'h1234_5678, 6'd17);
        send_item(OP_FLUSH, 32'h0000_0000, 6'd0);
        // Widths above the limit saturate.
        send_item(OP_WRITE, 32'hA5A5_A5A5, 6'd63);
        send_item(OP_WRITE, 32'h1234_5678, 6'd33);
        // Seven pending bits plus a full code give four bytes and leave seven behind.
        send_item(OP_WRITE, 32'h0000_007F, 6'd7);
        send_item(OP_WRITE, 32'hDEAD_BEEF, 6'd32);
        send_item(OP_WRITE, 32'h8000_0001, 6'd32);
        send_item(OP_WRITE, 32'hFFFF_FF3C, 6'd8);
        send_item(OP_WRITE, 32'hFFFF_FFFE, 6'd1);
        send_item(OP_FLUSH, 32'hFFFF_FFFF, 6'd40);
        send_item(OP_WRITE, 32'hFFFF_FFFF, 6'd31);
        send_item(OP_WRITE, 32'h5555_5555, 6'd1);
        send_item(OP_WRITE, 32'hAAAA_AAAA, 6'd20);
        send_item(OP_FLUSH, 32'h0000_0000, 6'd0);
        idle_sender($urandom_range(1, 6));

        // Random bursts with random gaps.
        while (done < RANDOM_GOAL) begin
            burst = $urandom_range(1, 12);
            repeat (burst) begin
                send_random(counted);
                done += counted;
            end
            if (!paused && done >= RANDOM_GOAL / 2) begin
                // Hold the sender until the block has delivered everything.
                paused = 1'b1;
                s_valid <= 1'b0;
                while (board.outstanding() > 0) @(posedge aclk);
                @(posedge aclk);
            end else begin
                idle_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
            end
        end
        send_item(OP_FLUSH, $urandom, 6'($urandom_range(0, 63)));
        s_valid <= 1'b0;

        // Drain, then give the pipeline time to show any extra beat.
        while (board.outstanding() > 0) @(posedge aclk);
        repeat (DRAIN_CYC) @(posedge aclk);

        if (board.outstanding() > 0) begin
            $error("%0d expected bytes never arrived", board.outstanding());
            board.mismatches++;
        end
        $display("Sent %0d input beats (%0d flushes, %0d over-limit widths).",
                 beats_sent, flush_beats, wide_beats);
        $display("Checked %0d output bytes under bursty input and mixed output stalls.",
                 board.bytes_checked);
        if (board.mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
